// ----- hw/rtl/snv_pkg.sv -----
// ----------------------------------------------------------------------------
// snv_pkg
// Shared types, constants and the sample qualification function of the
// nearest-valid-return scanner.
// ----------------------------------------------------------------------------
package snv_pkg;

  localparam int RANGE_W         = 16;
  localparam int IDX_W           = 13;
  localparam int CM_W            = 13;
  localparam int CFG_IDX_W       = 2;
  localparam int DEF_MAX_SAMPLES = 8192;

  localparam logic [RANGE_W-1:0] RST_MIN_RANGE  = 16'd900;
  localparam logic [RANGE_W-1:0] RST_MAX_RANGE  = 16'd12000;
  localparam logic [RANGE_W-1:0] RST_START_DIST = 16'd6000;
  localparam logic [RANGE_W-1:0] RST_NBR_TOL    = 16'd500;

  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam logic [RANGE_W-1:0] DIV10_MUL   = 16'd52429;
  localparam int                 DIV10_SHIFT = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE  = 2'd0,
    REG_MAX_RANGE  = 2'd1,
    REG_START_DIST = 2'd2,
    REG_NBR_TOL    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] min_range;
    logic [RANGE_W-1:0] max_range;
    logic [RANGE_W-1:0] start_dist;
    logic [RANGE_W-1:0] nbr_tol;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] dist_mm;
    logic [IDX_W-1:0]   idx;
    logic               found;
  } best_t;

  typedef struct packed {
    logic [RANGE_W-1:0] dist_mm;
    logic [IDX_W-1:0]   idx;
  } scan_result_t;

  function automatic logic [RANGE_W-1:0] abs_diff(input logic [RANGE_W-1:0] a,
                                                   input logic [RANGE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Take sample d as the new best if it is in range, closer than the best
  // (or equal, for index zero once a best is held) and agrees with a neighbor.
  function automatic best_t judge(input logic [RANGE_W-1:0] d,
                                  input logic [IDX_W-1:0]   idx,
                                  input logic [RANGE_W-1:0] nbr_a,
                                  input logic [RANGE_W-1:0] nbr_b,
                                  input logic               tie_ok,
                                  input cfg_t               cfg,
                                  input best_t              best);
    logic  in_range;
    logic  closer;
    logic  near;
    best_t res;
    in_range = (d > cfg.min_range) && (d < cfg.max_range);
    closer   = (d < best.dist_mm) || (tie_ok && best.found && (d == best.dist_mm));
    near     = (abs_diff(d, nbr_a) < cfg.nbr_tol) || (abs_diff(d, nbr_b) < cfg.nbr_tol);
    res      = best;
    if (in_range && closer && near) begin
      res.dist_mm = d;
      res.idx     = idx;
      res.found   = 1'b1;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/snv_if.sv -----
// ----------------------------------------------------------------------------
// snv_sample_if / snv_result_if
// Valid/ready channels for range samples and per-scan results.
// ----------------------------------------------------------------------------
interface snv_sample_if import snv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               last;

  modport source (output valid, output range_mm, output last, input ready);
  modport sink   (input valid, input range_mm, input last, output ready);
endinterface

interface snv_result_if import snv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CM_W-1:0]  min_distance_cm;
  logic [IDX_W-1:0] angle_index;

  modport source (output valid, output min_distance_cm, output angle_index, input ready);
  modport sink   (input valid, input min_distance_cm, input angle_index, output ready);
endinterface

// ----- hw/rtl/snv_in_stage.sv -----
// ----------------------------------------------------------------------------
// snv_in_stage
// Input register: holds one sample word until the scan stage takes it.
// ----------------------------------------------------------------------------
module snv_in_stage import snv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  snv_sample_if.sink         sample,
  input  logic               take,
  output logic               held_valid,
  output logic [RANGE_W-1:0] held_range,
  output logic               held_last
);

  assign sample.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample.ready) begin
      held_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      held_range <= sample.range_mm;
      held_last  <= sample.last;
    end
  end

endmodule

// ----- hw/rtl/snv_scan_core.sv -----
// ----------------------------------------------------------------------------
// snv_scan_core
// Scan state and qualification; loads the result register at end of scan.
// ----------------------------------------------------------------------------
module snv_scan_core import snv_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic [RANGE_W-1:0] in_range,
  input  logic               in_last,
  output logic               take,
  output logic               res_valid,
  output scan_result_t       res,
  input  logic               res_take
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [RANGE_W-1:0] first;
  logic [RANGE_W-1:0] first_next;
  logic [RANGE_W-1:0] second;
  logic [RANGE_W-1:0] second_next;
  logic [RANGE_W-1:0] prev;
  logic [RANGE_W-1:0] prev_next;
  logic [RANGE_W-1:0] bprev;
  logic [RANGE_W-1:0] bprev_next;
  best_t              best;
  best_t              best_step;
  best_t              best_tail;
  best_t              best_end;
  logic               stored;

  // End-of-scan words wait only for room in the result register.
  assign take = in_valid && (!in_last || !res_valid || res_take);

  always_comb begin
    stored      = (cnt < CNT_W'(MAX_SAMPLES));
    cnt_next    = cnt;
    first_next  = first;
    second_next = second;
    prev_next   = prev;
    bprev_next  = bprev;
    best_step   = best;
    if (stored) begin
      if (cnt == '0) begin
        first_next = in_range;
        best_step  = '{dist_mm: cfg.start_dist, idx: '0, found: 1'b0};
      end else if (cnt == CNT_W'(1)) begin
        second_next = in_range;
      end else begin
        // judge the middle sample once its right neighbor is known
        best_step = judge(prev, IDX_W'(cnt - CNT_W'(1)), bprev, in_range, 1'b0, cfg, best);
      end
      bprev_next = prev;
      prev_next  = in_range;
      cnt_next   = cnt + CNT_W'(1);
    end

    // wrap-around judges: final stored sample, then sample zero
    best_tail = best_step;
    best_end  = best_step;
    if (cnt_next == CNT_W'(1)) begin
      best_end = judge(first_next, '0, first_next, first_next, 1'b1, cfg, best_step);
    end else if (cnt_next >= CNT_W'(2)) begin
      best_tail = judge(prev_next, IDX_W'(cnt_next - CNT_W'(1)), bprev_next, first_next,
                        1'b0, cfg, best_step);
      best_end  = judge(first_next, '0, second_next, prev_next, 1'b1, cfg, best_tail);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        cnt <= in_last ? '0 : cnt_next;
      end
      if (take && in_last) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      first  <= first_next;
      second <= second_next;
      prev   <= prev_next;
      bprev  <= bprev_next;
      best   <= best_step;
      if (in_last) begin
        res.dist_mm <= best_end.dist_mm;
        res.idx     <= best_end.idx;
      end
    end
  end

endmodule

// ----- hw/rtl/snv_cm_out.sv -----
// ----------------------------------------------------------------------------
// snv_cm_out
// Output register: converts the best distance to centimeters and holds it.
// ----------------------------------------------------------------------------
module snv_cm_out import snv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         res_valid,
  input  scan_result_t res,
  output logic         res_take,
  snv_result_if.source result
);

  logic [2*RANGE_W-1:0] prod;

  assign res_take = res_valid && (!result.valid || result.ready);
  assign prod     = res.dist_mm * DIV10_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result.min_distance_cm <= prod[DIV10_SHIFT +: CM_W];
      result.angle_index     <= res.idx;
    end
  end

endmodule

// ----- hw/rtl/scan_nearest_valid_return.sv -----
// ----------------------------------------------------------------------------
// scan_nearest_valid_return
// Nearest trustworthy lidar return per scan.
// ----------------------------------------------------------------------------
// Feed range samples (mm) on the sample channel, last high on the final word
// of a scan; one result word per scan follows on the result channel with the
// nearest qualifying distance in truncated centimeters and its sample index
// (start distance / 10 and index 0 if nothing qualified). A sample qualifies
// when it lies strictly between min and max range, strictly below the best so
// far (index 0 also wins a tie), and within the neighbor tolerance of one
// circular neighbor. The block takes one sample per clock while not stalled:
// the sample register, the scan stage (a few 16-bit compares against held
// neighbors) and the centimeter output register each pass a word per cycle,
// and a scan result is registered in turn by both. Input stalls only when a
// finished result cannot drain and another end-of-scan word arrives behind it.
// Samples past MAX_SAMPLES in one scan are dropped. Write configuration only
// while idle; start distance is picked up at the first sample of each scan.
// ----------------------------------------------------------------------------
module scan_nearest_valid_return import snv_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RANGE_W-1:0]   cfg_data,
  snv_sample_if.sink           sample,
  snv_result_if.source         result
);

  cfg_t               cfg;
  logic               held_valid;
  logic [RANGE_W-1:0] held_range;
  logic               held_last;
  logic               take;
  logic               res_valid;
  scan_result_t       res;
  logic               res_take;

  // Configuration registers; decode the index by register name.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_range  <= RST_MIN_RANGE;
      cfg.max_range  <= RST_MAX_RANGE;
      cfg.start_dist <= RST_START_DIST;
      cfg.nbr_tol    <= RST_NBR_TOL;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_RANGE:  cfg.min_range  <= cfg_data;
        REG_MAX_RANGE:  cfg.max_range  <= cfg_data;
        REG_START_DIST: cfg.start_dist <= cfg_data;
        REG_NBR_TOL:    cfg.nbr_tol    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Register each incoming sample word.
  snv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .take       (take),
    .held_valid (held_valid),
    .held_range (held_range),
    .held_last  (held_last)
  );

  // Track neighbors and running best; judge wrap-around samples at end of scan.
  snv_scan_core #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (held_valid),
    .in_range  (held_range),
    .in_last   (held_last),
    .take      (take),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Convert to centimeters and hold the result word for the consumer.
  snv_cm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .result    (result)
  );

endmodule

// ----- tb/scan_nearest_valid_return_tb.sv -----
// ----------------------------------------------------------------------------
// scan_nearest_valid_return_tb
// Self-checking bench for the nearest-valid-return scanner: streams scans of
// range samples, predicts the nearest qualifying return of each scan and
// compares every result word with the prediction, field by field.
// ----------------------------------------------------------------------------
module scan_nearest_valid_return_tb;
  import snv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth: sample register, scan stage and centimeter register.
  localparam int          PIPE_DEPTH = 3;
  // A short scan capacity keeps the overlong scan cheap.
  localparam int unsigned SCAN_CAP   = 48;
  localparam int unsigned LONG_LEN   = SCAN_CAP + 3;

  typedef struct packed {
    logic [CM_W-1:0]  cm;
    logic [IDX_W-1:0] idx;
  } scan_word_t;

  // One row of the directed table; the expected word counts only when typed.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               last;
    logic               typed;
    logic [CM_W-1:0]    cm;
    logic [IDX_W-1:0]   idx;
  } stim_row_t;

  // Reset settings: min 900, max 12000, start 6000, tolerance 500.
  localparam stim_row_t DIR_ROWS [21] = '{
    '{16'd65535, 1'b1, 1'b1, 13'd600, 13'd0},  // invalid marker alone: nothing wins
    '{16'd0,     1'b1, 1'b1, 13'd600, 13'd0},  // zero range alone
    '{16'd1000,  1'b1, 1'b1, 13'd100, 13'd0},  // single sample is its own neighbor
    '{16'd2000,  1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd3000,  1'b1, 1'b1, 13'd600, 13'd0},  // pair too far apart
    '{16'd2000,  1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd2100,  1'b1, 1'b0, 13'd0,   13'd0},  // pair, each the other's neighbor
    '{16'd1500,  1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd1500,  1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd1500,  1'b1, 1'b0, 13'd0,   13'd0},  // three-way tie, lowest index wins
    '{16'd900,   1'b0, 1'b0, 13'd0,   13'd0},  // exactly at min range
    '{16'd901,   1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd905,   1'b1, 1'b0, 13'd0,   13'd0},
    '{16'd12000, 1'b0, 1'b0, 13'd0,   13'd0},  // exactly at max range
    '{16'd11999, 1'b1, 1'b1, 13'd600, 13'd0},  // in range but beyond start
    '{16'd5000,  1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd5000,  1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd4000,  1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd4100,  1'b1, 1'b0, 13'd0,   13'd0},  // best moves along the scan
    '{16'd65535, 1'b0, 1'b0, 13'd0,   13'd0},
    '{16'd65534, 1'b1, 1'b1, 13'd600, 13'd0}
  };

  // Settings walked after the directed part, extremes among them.
  localparam cfg_t PHASES [7] = '{
    '{16'd900,   16'd12000, 16'd6000,  16'd500},
    '{16'd0,     16'd65535, 16'd65535, 16'd65535},
    '{16'd0,     16'd65535, 16'd65535, 16'd0},
    '{16'd65535, 16'd0,     16'd0,     16'd1},
    '{16'd300,   16'd20000, 16'd15000, 16'd200},
    '{16'd2000,  16'd9000,  16'd9000,  16'd1},
    '{16'd900,   16'd12000, 16'd6000,  16'd500}
  };
  localparam int unsigned PHASE_ITEMS [7] = '{120, 130, 90, 60, 150, 100, 100};

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RANGE_W-1:0] cfg_data;

  snv_sample_if samp_ch ();
  snv_result_if res_ch ();

  scan_nearest_valid_return #(
    .MAX_SAMPLES (SCAN_CAP)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (samp_ch),
    .result    (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #3_200_000;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the settings as the block holds them and the scan so far.
  // --------------------------------------------------------------------------
  logic [RANGE_W-1:0] lim_min, lim_max, lim_start, lim_tol;
  logic [RANGE_W-1:0] s_first, s_second, s_prev, s_prev2;
  int unsigned        s_count;
  logic [RANGE_W-1:0] best_mm;
  int unsigned        best_at;
  bit                 best_held;

  scan_word_t  nearest_q [$];
  int unsigned err_cnt      = 0;
  int unsigned items_sent   = 0;
  int unsigned scans_seen   = 0;
  int unsigned settings_run = 0;

  function automatic logic [RANGE_W-1:0] spread_mm(input logic [RANGE_W-1:0] a,
                                                   input logic [RANGE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void clear_scan_state();
    s_first   = '0;
    s_second  = '0;
    s_prev    = '0;
    s_prev2   = '0;
    s_count   = 0;
    best_mm   = lim_start;
    best_at   = 0;
    best_held = 1'b0;
  endfunction

  // Take d as the new best when it is in range, closer than the best and
  // agrees with one neighbor. An equal distance counts only for index zero,
  // which is weighed last but must still win ties.
  function automatic void weigh_candidate(input logic [RANGE_W-1:0] d,
                                          input int unsigned at,
                                          input logic [RANGE_W-1:0] nbr_a,
                                          input logic [RANGE_W-1:0] nbr_b,
                                          input bit tie_ok);
    bit closer;
    if (!(d > lim_min && d < lim_max))
      return;
    closer = (d < best_mm) || (tie_ok && best_held && d == best_mm);
    if (!closer)
      return;
    if (spread_mm(d, nbr_a) < lim_tol || spread_mm(d, nbr_b) < lim_tol) begin
      best_mm   = d;
      best_at   = at;
      best_held = 1'b1;
    end
  endfunction

  // Advance the scan by one accepted word; return 1 with the nearest return
  // when the word closes the scan.
  function automatic bit track_sample(input logic [RANGE_W-1:0] x, input bit last,
                                      output scan_word_t w);
    int unsigned n;
    n = s_count;
    w = '0;
    // Samples past the capacity are dropped outright.
    if (n < SCAN_CAP) begin
      if (n == 0) begin
        s_first   = x;
        best_mm   = lim_start;
        best_at   = 0;
        best_held = 1'b0;
      end else if (n == 1) begin
        s_second = x;
      end else begin
        // The previous sample now has both neighbors.
        weigh_candidate(s_prev, n - 1, s_prev2, x, 1'b0);
      end
      s_prev2 = s_prev;
      s_prev  = x;
      s_count = n + 1;
    end
    if (!last)
      return 1'b0;
    // Close the ring: the final stored sample wraps to the first, and the
    // first sample takes the final one as its left neighbor.
    n = s_count;
    if (n == 1) begin
      weigh_candidate(s_first, 0, s_first, s_first, 1'b1);
    end else if (n >= 2) begin
      weigh_candidate(s_prev, n - 1, s_prev2, s_first, 1'b0);
      weigh_candidate(s_first, 0, s_second, s_prev, 1'b1);
    end
    w.cm  = CM_W'(best_mm / 10);
    w.idx = IDX_W'(best_at);
    clear_scan_state();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------

  // Hold off at random, present one word, wait for it to be taken and
  // fold it into the prediction. A typed word replaces the predicted one.
  task automatic send_sample(input logic [RANGE_W-1:0] x, input bit last,
                             input int unsigned max_gap, input bit typed,
                             input scan_word_t typed_w);
    int unsigned hold;
    scan_word_t  w;
    hold = $urandom_range(0, max_gap);
    repeat (hold) begin
      @(negedge clk);
      samp_ch.valid <= 1'b0;
    end
    @(negedge clk);
    samp_ch.valid    <= 1'b1;
    samp_ch.range_mm <= x;
    samp_ch.last     <= last;
    do @(posedge clk); while (samp_ch.ready !== 1'b1);
    items_sent++;
    if (track_sample(x, last, w))
      nearest_q.push_back(typed ? typed_w : w);
  endtask

  // Drop valid, wait for every pending result, then let the pipe run dry.
  task automatic settle_block();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    samp_ch.valid <= 1'b0;
    while (nearest_q.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic program_reg(input cfg_reg_t r, input logic [RANGE_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      REG_MIN_RANGE:  lim_min   = v;
      REG_MAX_RANGE:  lim_max   = v;
      REG_START_DIST: lim_start = v;
      REG_NBR_TOL:    lim_tol   = v;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    program_reg(REG_MIN_RANGE,  c.min_range);
    program_reg(REG_MAX_RANGE,  c.max_range);
    program_reg(REG_START_DIST, c.start_dist);
    program_reg(REG_NBR_TOL,    c.nbr_tol);
    @(negedge clk);
    cfg_we <= 1'b0;
    best_mm = lim_start;
    settings_run++;
  endtask

  // Random scans until the budget is used. Most scans wander around a center
  // in steps near the tolerance so neighbors agree often enough; some are
  // pure noise. Short scans dominate so the wrap-around cases come often.
  task automatic run_scans(input int unsigned budget);
    int unsigned done_items;
    int unsigned len;
    int unsigned max_gap;
    int unsigned pick;
    int unsigned spr;
    int          ctr;
    int          v;
    bit          noisy;
    logic [RANGE_W-1:0] x;
    done_items = 0;
    while (done_items < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 3)
        len = $urandom_range(1, 2);
      else if (pick < 9)
        len = $urandom_range(3, 12);
      else
        len = $urandom_range(13, 40);
      noisy   = ($urandom_range(0, 4) == 0);
      max_gap = ($urandom_range(0, 4) == 0) ? 0 : 14;
      spr     = (lim_tol > 2000) ? 2000 : (lim_tol < 20) ? 20 : lim_tol;
      case ($urandom_range(0, 3))
        0:       ctr = $urandom_range(0, 65535);
        1:       ctr = $urandom_range(0, 20000);
        default: ctr = $urandom_range(lim_min, lim_max);
      endcase
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 15);
        if (noisy || pick == 2) begin
          x = RANGE_W'($urandom);
        end else if (pick == 0) begin
          x = '1;
        end else if (pick == 1) begin
          x = '0;
        end else begin
          v = ctr + int'($urandom_range(0, 2 * spr)) - int'(spr);
          if (v < 0)
            v = 0;
          if (v > 65535)
            v = 65535;
          ctr = v;
          x   = v[RANGE_W-1:0];
        end
        send_sample(x, i == len - 1, max_gap, 1'b0, '0);
      end
      done_items += len;
    end
  endtask

  // One scan longer than the capacity: mostly invalid returns, a tight
  // cluster at the top of the index range with the closest at the very last
  // stored index, and a tail that the block must drop.
  task automatic run_overlong_scan();
    logic [RANGE_W-1:0] x;
    for (int unsigned i = 0; i < LONG_LEN; i++) begin
      if (i == SCAN_CAP - 1)
        x = 16'd950;
      else if (i >= SCAN_CAP - 8)
        x = RANGE_W'(1000 + $urandom_range(0, 50));
      else if ($urandom_range(0, 99) == 0)
        x = RANGE_W'($urandom);
      else
        x = '1;
      send_sample(x, i == LONG_LEN - 1, 2, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall at random, check each word against the oldest
  // prediction.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    scan_word_t  due;
    res_ch.ready <= 1'b0;
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      repeat (hold) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      scans_seen++;
      if (nearest_q.size() == 0) begin
        $error("result word with no scan pending: min_distance_cm %0d angle_index %0d",
               res_ch.min_distance_cm, res_ch.angle_index);
        err_cnt++;
      end else begin
        due = nearest_q.pop_front();
        if (res_ch.min_distance_cm !== due.cm) begin
          $error("min_distance_cm: expected %0d, got %0d", due.cm, res_ch.min_distance_cm);
          err_cnt++;
        end
        if (res_ch.angle_index !== due.idx) begin
          $error("angle_index: expected %0d, got %0d", due.idx, res_ch.angle_index);
          err_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_MIN_RANGE;
    cfg_data         <= '0;
    samp_ch.valid    <= 1'b0;
    samp_ch.range_mm <= '0;
    samp_ch.last     <= 1'b0;

    lim_min   = RST_MIN_RANGE;
    lim_max   = RST_MAX_RANGE;
    lim_start = RST_START_DIST;
    lim_tol   = RST_NBR_TOL;
    clear_scan_state();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table at reset settings; every third word goes back to back.
    for (int k = 0; k < $size(DIR_ROWS); k++)
      send_sample(DIR_ROWS[k].range_mm, DIR_ROWS[k].last, (k % 3 == 0) ? 0 : 14,
                  DIR_ROWS[k].typed, '{cm: DIR_ROWS[k].cm, idx: DIR_ROWS[k].idx});

    // Random phases; reprogram only once the block has drained.
    for (int p = 0; p < $size(PHASES); p++) begin
      settle_block();
      apply_settings(PHASES[p]);
      run_scans(PHASE_ITEMS[p]);
      if (p == 0)
        run_overlong_scan();
    end

    settle_block();
    if (nearest_q.size() != 0) begin
      $error("%0d scan results never arrived", nearest_q.size());
      err_cnt++;
    end

    $display("Covered %0d scans from %0d sample words under %0d register settings,",
             scans_seen, items_sent, settings_run + 1);
    $display("including single-sample, paired, tied and overlong scans.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
